@@ sv/npm_pkg.sv @@
`timescale 1ns / 1ps

package npm_pkg;

    localparam int unsigned TableDepth = 16;
    localparam int unsigned IdxW       = 4;
    localparam int unsigned FreqW      = 21;
    localparam int unsigned PhysW      = 8;
    localparam int unsigned LogFrac    = 24;
    localparam int unsigned LogW       = 29;
    localparam int unsigned MantW      = 31;
    localparam int unsigned CentsW     = 20;
    localparam int unsigned TolW       = 19;
    localparam int unsigned SizeW      = 5;
    localparam int unsigned ProdW      = 44;

    localparam logic [ProdW-1:0] CentsPerOctave = 44'd19200;
    localparam logic [ProdW-1:0] RoundHalf      = 44'd8388608;
    localparam logic [TolW-1:0]  CentsLimit     = 19'd403200;
    localparam logic [TolW-1:0]  TolReset       = 19'd800;
    localparam logic [4:0]       LogSteps       = 5'd24;

    typedef enum logic {
        REG_TABLE_SIZE = 1'b0,
        REG_TOLERANCE  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_MATCH = 1'b1
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOG  = 4'b0010,
        S_WALK = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic [FreqW-1:0] freq;
        logic [PhysW-1:0] phys;
        logic             pv;
        logic [LogW-1:0]  logv;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

endpackage

@@ sv/npm_log2.sv @@
`timescale 1ns / 1ps

module npm_log2 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [npm_pkg::FreqW-1:0] i_x,
    output logic                      o_done,
    output logic [npm_pkg::LogW-1:0]  o_log
);

    logic [npm_pkg::MantW-1:0]   r_m;
    logic [4:0]                  r_n;
    logic [npm_pkg::LogFrac-1:0] r_frac;
    logic [4:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [4:0]                  n_n;
    logic [2*npm_pkg::MantW-1:0] w_sq;
    logic [31:0]                 w_top;

    // position of the top set bit
    always_comb begin
        n_n = 5'd0;
        for (int k = 0; k < npm_pkg::FreqW; k++) begin
            if (i_x[k]) begin
                n_n = 5'(k);
            end
        end
    end

    assign w_sq  = (2*npm_pkg::MantW)'(r_m) * (2*npm_pkg::MantW)'(r_m);
    assign w_top = w_sq[2*npm_pkg::MantW-1:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == npm_pkg::LogSteps - 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= n_n;
            r_m    <= npm_pkg::MantW'(i_x) << (5'd30 - n_n);
            r_frac <= '0;
        end else if (r_busy) begin
            // square, then halve when the mantissa reaches two
            r_frac <= {r_frac[npm_pkg::LogFrac-2:0], w_top[31]};
            r_m    <= w_top[31] ? w_top[31:1] : w_top[30:0];
        end
    end

    assign o_done = r_done;
    assign o_log  = {r_n, r_frac};

endmodule

@@ sv/npm_cell.sv @@
`timescale 1ns / 1ps

module npm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  npm_pkg::t_cell_ctl i_ctl,
    input  npm_pkg::t_entry    i_next,
    input  npm_pkg::t_entry    i_wdata,
    output npm_pkg::t_entry    o_q
);

    npm_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= i_next;
        end else if (i_ctl.wr) begin
            r_q <= i_wdata;
        end
    end

    assign o_q = r_q;

endmodule

@@ sv/nearest_note_pitch_matcher.sv @@
`timescale 1ns / 1ps

// Nearest-note matcher. On a load word (mode 0) busy stays high while
// the log2 unit is started and runs 24 squaring steps on the reference
// frequency, then the entry and its log are written into its slot of a ring of
// 16 cells. A new word is taken as soon as busy is low, never while it is high.
// A match word (mode 1) keeps busy high while the log of the pitch is formed,
// while the ring turns once past the two-stage cents compare and while the
// result is registered. The result is shown with strobe for exactly one
// cycle as busy falls. The receiver cannot stall the result, so sample it
// on that cycle. A load gives no result.
module nearest_note_pitch_matcher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        strobe,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [npm_pkg::TolW-1:0]    i_cfg_wdata,
    input  logic                        i_mode,
    input  logic [npm_pkg::IdxW-1:0]    i_entry_index,
    input  logic [npm_pkg::FreqW-1:0]   i_entry_frequency,
    input  logic [npm_pkg::PhysW-1:0]   i_entry_physical,
    input  logic                        i_entry_physical_valid,
    input  logic [npm_pkg::FreqW-1:0]   i_pitch,
    output logic                        o_note_hit,
    output logic [npm_pkg::IdxW-1:0]    o_best_index,
    output logic                        o_physical_valid,
    output logic [npm_pkg::PhysW-1:0]   o_phys_map,
    output logic signed [npm_pkg::CentsW-1:0] o_cent_error,
    output logic [npm_pkg::FreqW-1:0]   o_ref_freq,
    output logic [npm_pkg::FreqW-1:0]   o_measured_frequency
);

    npm_pkg::t_state r_state;
    logic [npm_pkg::SizeW-1:0] r_size;
    logic [npm_pkg::TolW-1:0]  r_tol;
    logic                      r_mode;
    logic [npm_pkg::IdxW-1:0]  r_idx;
    logic [npm_pkg::FreqW-1:0] r_wfreq;
    logic [npm_pkg::PhysW-1:0] r_wphys;
    logic                      r_wpv;
    logic [npm_pkg::FreqW-1:0] r_pitch;
    logic [npm_pkg::LogW-1:0]  r_lp;
    logic [4:0]                r_step;

    logic                      r_s1_v;
    logic                      r_s1_neg;
    logic [npm_pkg::ProdW-1:0] r_s1_prod;
    logic [npm_pkg::IdxW-1:0]  r_s1_idx;
    logic [npm_pkg::FreqW-1:0] r_s1_freq;
    logic [npm_pkg::PhysW-1:0] r_s1_phys;
    logic                      r_s1_pv;

    logic                      r_found;
    logic [npm_pkg::TolW-1:0]  r_best_abs;
    logic                      r_best_neg;
    logic [npm_pkg::IdxW-1:0]  r_best_idx;
    logic [npm_pkg::FreqW-1:0] r_best_freq;
    logic [npm_pkg::PhysW-1:0] r_best_phys;
    logic                      r_best_pv;

    logic                      r_strobe;

    logic                      w_log_start;
    logic                      w_log_done;
    logic [npm_pkg::LogW-1:0]  w_log;
    logic                      w_shift;
    logic                      w_wr;
    npm_pkg::t_entry           w_cell [npm_pkg::TableDepth];
    npm_pkg::t_entry           w_wdata;
    npm_pkg::t_entry           w_head;
    logic [npm_pkg::SizeW-1:0] w_count;
    logic                      w_neg;
    logic [npm_pkg::LogW-1:0]  w_mag;
    logic [npm_pkg::ProdW-1:0] w_sum;
    logic [npm_pkg::CentsW-1:0] w_craw;
    logic [npm_pkg::TolW-1:0]  w_c;
    logic                      w_take;
    logic                      w_match;

    assign busy        = (r_state != npm_pkg::S_IDLE);
    assign strobe      = r_strobe;
    assign w_log_start = start && !busy;
    assign w_shift     = (r_state == npm_pkg::S_WALK) && !r_step[4];
    assign w_wr        = (r_state == npm_pkg::S_LOG) && w_log_done
                         && (r_mode == npm_pkg::MODE_LOAD);
    assign w_wdata     = '{freq: r_wfreq, phys: r_wphys, pv: r_wpv, logv: w_log};
    assign w_head      = w_cell[0];
    assign w_count     = (r_size > npm_pkg::SizeW'(npm_pkg::TableDepth))
                         ? npm_pkg::SizeW'(npm_pkg::TableDepth) : r_size;

    npm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_log_start),
        .i_x     ((i_mode == npm_pkg::MODE_MATCH) ? i_pitch : i_entry_frequency),
        .o_done  (w_log_done),
        .o_log   (w_log)
    );

    // ring of cells: rotate towards cell zero, write in place on a load
    for (genvar g = 0; g < npm_pkg::TableDepth; g++) begin : g_cell
        npm_pkg::t_cell_ctl w_ctl;
        assign w_ctl = '{shift: w_shift, wr: w_wr && (r_idx == npm_pkg::IdxW'(g))};
        npm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_next  (w_cell[(g + 1) % npm_pkg::TableDepth]),
            .i_wdata (w_wdata),
            .o_q     (w_cell[g])
        );
    end

    assign w_neg  = (r_lp < w_head.logv);
    assign w_mag  = w_neg ? (w_head.logv - r_lp) : (r_lp - w_head.logv);
    assign w_sum  = r_s1_prod + npm_pkg::RoundHalf;
    assign w_craw = w_sum[npm_pkg::ProdW-1:npm_pkg::LogFrac];
    assign w_c    = (w_craw > npm_pkg::CentsW'(npm_pkg::CentsLimit))
                    ? npm_pkg::CentsLimit : w_craw[npm_pkg::TolW-1:0];
    assign w_take = r_s1_v && (!r_found || (w_c < r_best_abs));
    assign w_match = r_found && (r_best_abs <= r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
            r_tol  <= npm_pkg::TolReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                npm_pkg::REG_TABLE_SIZE: r_size <= i_cfg_wdata[npm_pkg::SizeW-1:0];
                npm_pkg::REG_TOLERANCE:  r_tol  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= npm_pkg::S_IDLE;
            r_step   <= '0;
            r_strobe <= 1'b0;
            r_s1_v   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                npm_pkg::S_IDLE: begin
                    if (start) begin
                        r_state <= npm_pkg::S_LOG;
                    end
                end
                npm_pkg::S_LOG: begin
                    if (w_log_done) begin
                        r_step  <= '0;
                        r_found <= 1'b0;
                        r_s1_v  <= 1'b0;
                        r_state <= (r_mode == npm_pkg::MODE_LOAD)
                                   ? npm_pkg::S_IDLE : npm_pkg::S_WALK;
                    end
                end
                npm_pkg::S_WALK: begin
                    r_step <= r_step + 5'd1;
                    r_s1_v <= !r_step[4] && (r_step < w_count)
                              && (w_head.freq != '0) && (r_pitch != '0);
                    if (w_take) begin
                        r_found <= 1'b1;
                    end
                    if (r_step[4]) begin
                        r_state <= npm_pkg::S_OUT;
                    end
                end
                npm_pkg::S_OUT: begin
                    r_strobe <= 1'b1;
                    r_state  <= npm_pkg::S_IDLE;
                end
                default: r_state <= npm_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_log_start) begin
            r_mode  <= i_mode;
            r_idx   <= i_entry_index;
            r_wfreq <= i_entry_frequency;
            r_wphys <= i_entry_physical;
            r_wpv   <= i_entry_physical_valid;
            r_pitch <= i_pitch;
        end
        if ((r_state == npm_pkg::S_LOG) && w_log_done) begin
            r_lp <= w_log;
        end
        // stage one: scale the log difference to sixteenths of a cent
        r_s1_neg  <= w_neg;
        r_s1_prod <= npm_pkg::ProdW'(w_mag) * npm_pkg::CentsPerOctave;
        r_s1_idx  <= r_step[npm_pkg::IdxW-1:0];
        r_s1_freq <= w_head.freq;
        r_s1_phys <= w_head.phys;
        r_s1_pv   <= w_head.pv;
        // stage two: keep the nearest, lower index on a tie
        if (w_take) begin
            r_best_abs  <= w_c;
            r_best_neg  <= r_s1_neg;
            r_best_idx  <= r_s1_idx;
            r_best_freq <= r_s1_freq;
            r_best_phys <= r_s1_phys;
            r_best_pv   <= r_s1_pv;
        end
        if (r_state == npm_pkg::S_OUT) begin
            o_note_hit           <= w_match;
            o_best_index         <= w_match ? r_best_idx : '0;
            o_physical_valid     <= w_match && r_best_pv;
            o_phys_map           <= (w_match && r_best_pv) ? r_best_phys : '0;
            o_ref_freq           <= w_match ? r_best_freq : '0;
            o_measured_frequency <= r_pitch;
            if (!w_match) begin
                o_cent_error <= '0;
            end else if (r_best_neg) begin
                o_cent_error <= $signed(~{1'b0, r_best_abs} + npm_pkg::CentsW'(1));
            end else begin
                o_cent_error <= $signed({1'b0, r_best_abs});
            end
        end
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == npm_pkg::S_IDLE))
        else $error("result strobe outside idle");

    a_shift_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> !w_wr && (r_mode == npm_pkg::MODE_MATCH))
        else $error("ring rotates outside a match");

    a_out_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npm_pkg::S_OUT) |-> $past(r_state == npm_pkg::S_WALK)
        && (r_step == 5'd17))
        else $error("result before the ring has turned once");

    a_best_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_strobe) && o_note_hit |-> o_ref_freq != '0)
        else $error("match against an unused entry");

endmodule
